// ----- hdl/blm_pkg.sv -----
// Shared widths, constants, payload and control types for the battery level monitor.
package blm_pkg;

  // Window and converter defaults
  localparam int SAMPLES_PER_READING_DEF = 16;
  localparam int ADC_BITS                = 12;

  // Field widths
  localparam int SAMPLE_W   = 12;
  localparam int UVPC_W     = 12;
  localparam int RATIO_W    = 13;
  localparam int RATIO_FRAC = 8;
  localparam int MV_W       = 15;
  localparam int PCT_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // Datapath widths
  localparam int UV_W       = SAMPLE_W + UVPC_W;
  localparam int SCALED_W   = UV_W + RATIO_W - RATIO_FRAC;
  localparam int NUM_W      = MV_W + 8;
  localparam int DIVIDEND_W = NUM_W;
  localparam int DIVISOR_W  = MV_W + 1;
  localparam int LOW_W      = MV_W + 4;

  // Microvolts to millivolts by reciprocal multiply, exact below the clamp limit
  localparam int MV_DIV_W       = 25;
  localparam int MV_RECIP_W     = 26;
  localparam int MV_RECIP_SHIFT = 35;

  // Effective sample bits after masking to the converter resolution
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
    (ADC_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << ADC_BITS) - 1);

  // Arithmetic constants
  localparam logic [RATIO_W-1:0]    RATIO_ONE     = 13'd256;
  localparam logic [SCALED_W-1:0]   UV_ROUND      = 29'd500;
  localparam logic [SCALED_W-1:0]   UV_CLAMP_HIGH = 29'd20001000;
  localparam logic [MV_RECIP_W-1:0] MV_RECIP      = 26'd34359739;
  localparam logic [MV_W-1:0]       MV_MIN        = 15'd100;
  localparam logic [MV_W-1:0]       MV_MAX        = 15'd20000;
  localparam logic [MV_W-1:0]       MV_HYST       = 15'd50;
  localparam logic [PCT_W-1:0]      PCT_NONE      = 7'd0;
  localparam logic [PCT_W-1:0]      PCT_FULL      = 7'd100;
  localparam logic [NUM_W-1:0]      PCT_SCALE     = 23'd200;
  localparam logic [LOW_W-1:0]      LOW_TENS      = 19'd10;
  localparam logic [LOW_W-1:0]      LOW_NINES     = 19'd9;

  // Register reset values
  localparam logic [UVPC_W-1:0]  UVPC_RST  = 12'd800;
  localparam logic [RATIO_W-1:0] RATIO_RST = 13'd256;
  localparam logic [MV_W-1:0]    EMPTY_RST = 15'd3300;
  localparam logic [MV_W-1:0]    FULL_RST  = 15'd4200;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UV_PER_COUNT = 2'd0,
    CFG_RATIO_Q8     = 2'd1,
    CFG_EMPTY_MV     = 2'd2,
    CFG_FULL_MV      = 2'd3
  } cfg_reg_e;

  // Payloads
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                read_failed;
  } sample_item_t;

  typedef struct packed {
    logic [MV_W-1:0]  level_millivolts;
    logic [PCT_W-1:0] charge_percent;
    logic             is_low;
  } report_item_t;

  // Controller to datapath
  typedef struct packed {
    logic acc_en;
    logic acc_clr;
    logic div_start;
    logic load_avg;
    logic load_uv;
    logic load_scaled;
    logic load_mv;
    logic load_low;
    logic load_pct_direct;
    logic load_pct_div;
    logic load_out;
  } blm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_sample;
    logic div_busy;
    logic div_done;
    logic pct_direct;
    logic changed;
  } blm_status_t;

endpackage

// ----- hdl/blm_div.sv -----
// Restoring divider, one quotient bit per cycle.
module blm_div import blm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [STEP_W-1:0]     steps;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;
  logic [DIVISOR_W-1:0]  rem_next;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    shifted  = {rem, quo[DIVIDEND_W-1]};
    diff     = shifted - {1'b0, dvs};
    fits     = (shifted >= {1'b0, dvs});
    rem_next = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
  end

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        steps <= STEP_W'(DIVIDEND_W);
      end else if (steps != '0) begin
        steps <= steps - 1'b1;
        done  <= (steps == STEP_W'(1));
      end
    end
  end

  // Shift quotient bits in, hold remainder
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (steps != '0) begin
      quo <= {quo[DIVIDEND_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign busy     = (steps != '0);
  assign quotient = quo;

endmodule

// ----- hdl/blm_datapath.sv -----
// Datapath: registers, window accumulator, scaling, percent, change test and result register.
module blm_datapath import blm_pkg::*; #(
  parameter int SAMPLES_PER_READING = SAMPLES_PER_READING_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  sample_item_t          sample_item,
  input  blm_cmd_t              cmd,
  output blm_status_t           status,
  output report_item_t          report_item
);

  localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
  localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES_PER_READING);

  // Window average by reciprocal multiply, exact for any sum below 2^16
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int AVG_PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((1 << RECIP_SHIFT) + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING);

  // Configuration registers
  logic [UVPC_W-1:0]  uv_per_count;
  logic [RATIO_W-1:0] ratio_q8;
  logic [MV_W-1:0]    empty_mv;
  logic [MV_W-1:0]    full_mv;

  // Window accumulator
  logic [SUM_W-1:0]   sample_sum;
  logic [CNT_W-1:0]   sample_count;
  logic [SAMPLE_W-1:0] sample_eff;

  // Working registers; scaled carries the half-millivolt rounding term
  logic [SAMPLE_W-1:0] avg;
  logic [UV_W-1:0]     uv;
  logic [SCALED_W-1:0] scaled;
  logic [MV_W-1:0]     mv;
  logic [PCT_W-1:0]    pct;
  logic                low;

  // Last reported values
  logic                have_report;
  logic [MV_W-1:0]     reported_mv;
  logic [PCT_W-1:0]    reported_pct;
  logic                reported_low;

  // Divider interface
  logic                  div_busy;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [DIVIDEND_W-1:0] div_quotient;

  // Combinational terms
  logic [AVG_PROD_W-1:0]          avg_prod;
  logic [UV_W+RATIO_W-1:0]        ratio_prod;
  logic [SCALED_W-1:0]            scaled_sel;
  logic [MV_DIV_W+MV_RECIP_W-1:0] mv_prod;
  logic [MV_W-1:0]                mv_quot;
  logic [MV_W-1:0]                mv_clamped;
  logic [MV_W-1:0]                span;
  logic [MV_W-1:0]                above_empty;
  logic [NUM_W-1:0]               pct_num;
  logic                           pct_direct;
  logic                           low_calc;
  logic [MV_W-1:0]                mv_diff;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      uv_per_count <= UVPC_RST;
      ratio_q8     <= RATIO_RST;
      empty_mv     <= EMPTY_RST;
      full_mv      <= FULL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UV_PER_COUNT: uv_per_count <= cfg_data[UVPC_W-1:0];
        CFG_RATIO_Q8:     ratio_q8     <= cfg_data[RATIO_W-1:0];
        CFG_EMPTY_MV:     empty_mv     <= cfg_data[MV_W-1:0];
        CFG_FULL_MV:      full_mv      <= cfg_data[MV_W-1:0];
        default: ;
      endcase
    end
  end

  // Accumulate samples; a failed read counts but adds zero
  assign sample_eff = sample_item.read_failed ? '0 : (sample_item.sample & SAMPLE_MASK);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (cmd.acc_clr) begin
      sample_sum <= '0;
    end else if (cmd.acc_en) begin
      sample_sum   <= sample_sum + SUM_W'(sample_eff);
      sample_count <= status.last_sample ? '0 : sample_count + 1'b1;
    end
  end

  // Percent divide operands
  assign div_dividend = pct_num;
  assign div_divisor  = {span, 1'b0};

  blm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Average, scale, clamp, percent and low terms
  always_comb begin
    avg_prod    = AVG_PROD_W'(sample_sum) * AVG_PROD_W'(AVG_RECIP);
    ratio_prod  = (UV_W + RATIO_W)'(uv) * (UV_W + RATIO_W)'(ratio_q8);
    scaled_sel  = (ratio_q8 > RATIO_ONE) ? ratio_prod[UV_W+RATIO_W-1:RATIO_FRAC]
                                         : SCALED_W'(uv);
    mv_prod     = (MV_DIV_W + MV_RECIP_W)'(scaled[MV_DIV_W-1:0]) *
                  (MV_DIV_W + MV_RECIP_W)'(MV_RECIP);
    mv_quot     = mv_prod[MV_RECIP_SHIFT +: MV_W];
    if (scaled >= UV_CLAMP_HIGH) begin
      mv_clamped = MV_MAX;
    end else if (mv_quot < MV_MIN) begin
      mv_clamped = MV_MIN;
    end else begin
      mv_clamped = mv_quot;
    end
    span        = full_mv - empty_mv;
    above_empty = mv - empty_mv;
    pct_num     = NUM_W'(above_empty) * PCT_SCALE + NUM_W'(span);
    pct_direct  = (mv <= empty_mv) || (mv >= full_mv);
    low_calc    = (LOW_W'(mv) * LOW_TENS) <= (LOW_W'(empty_mv) * LOW_NINES + LOW_W'(full_mv));
    mv_diff     = (mv > reported_mv) ? (mv - reported_mv) : (reported_mv - mv);
  end

  // Advance the working registers
  always_ff @(posedge clk) begin
    if (cmd.load_avg) begin
      avg <= avg_prod[RECIP_SHIFT +: SAMPLE_W];
    end
    if (cmd.load_uv) begin
      uv <= UV_W'(avg) * UV_W'(uv_per_count);
    end
    if (cmd.load_scaled) begin
      scaled <= scaled_sel + UV_ROUND;
    end
    if (cmd.load_mv) begin
      mv <= mv_clamped;
    end
    if (cmd.load_low) begin
      low <= low_calc;
    end
    if (cmd.load_pct_direct) begin
      pct <= (mv <= empty_mv) ? PCT_NONE : PCT_FULL;
    end else if (cmd.load_pct_div) begin
      pct <= div_quotient[PCT_W-1:0];
    end
    if (cmd.load_out) begin
      report_item.level_millivolts <= mv;
      report_item.charge_percent   <= pct;
      report_item.is_low           <= low;
    end
  end

  // Remember the last report
  always_ff @(posedge clk) begin
    if (rst) begin
      have_report  <= 1'b0;
      reported_mv  <= '0;
      reported_pct <= '0;
      reported_low <= 1'b0;
    end else if (cmd.load_out) begin
      have_report  <= 1'b1;
      reported_mv  <= mv;
      reported_pct <= pct;
      reported_low <= low;
    end
  end

  // Status back to the controller
  always_comb begin
    status.last_sample = (sample_count == CNT_W'(SAMPLES_PER_READING - 1));
    status.div_busy    = div_busy;
    status.div_done    = div_done;
    status.pct_direct  = pct_direct;
    status.changed     = !have_report || (pct != reported_pct) ||
                         (mv_diff > MV_HYST) || (low != reported_low);
  end

endmodule

// ----- hdl/blm_ctrl.sv -----
// Controller: sequences accumulation, scaling, the percent divide and the result handoff.
module blm_ctrl import blm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  output logic        report_valid,
  input  logic        report_stall,
  input  blm_status_t status,
  output blm_cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b00000001,
    S_AVG      = 8'b00000010,
    S_UV       = 8'b00000100,
    S_RATIO    = 8'b00001000,
    S_MV       = 8'b00010000,
    S_PCT      = 8'b00100000,
    S_WAIT_PCT = 8'b01000000,
    S_REPORT   = 8'b10000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free     = !report_valid || !report_stall;
  assign sample_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.acc_en = 1'b1;
          if (status.last_sample) begin
            state_next = S_AVG;
          end
        end
      end
      S_AVG: begin
        cmd.load_avg = 1'b1;
        cmd.acc_clr  = 1'b1;
        state_next   = S_UV;
      end
      S_UV: begin
        cmd.load_uv = 1'b1;
        state_next  = S_RATIO;
      end
      S_RATIO: begin
        cmd.load_scaled = 1'b1;
        state_next      = S_MV;
      end
      S_MV: begin
        cmd.load_mv = 1'b1;
        state_next  = S_PCT;
      end
      S_PCT: begin
        cmd.load_low = 1'b1;
        if (status.pct_direct) begin
          cmd.load_pct_direct = 1'b1;
          state_next          = S_REPORT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_WAIT_PCT;
        end
      end
      S_WAIT_PCT: begin
        if (status.div_done) begin
          cmd.load_pct_div = 1'b1;
          state_next       = S_REPORT;
        end
      end
      S_REPORT: begin
        // Drop an unchanged reading, otherwise hold until the result register frees
        if (!status.changed) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      report_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        report_valid <= 1'b1;
      end else if (!report_stall) begin
        report_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/battery_level_monitor.sv -----
// Top level of the battery level monitor: controller, datapath and checks.
//
//  Channel  | Signals                                  | Handshake
//  ---------+------------------------------------------+---------------------------
//  samples  | sample_valid, sample_stall, sample_item  | taken on valid && !stall
//  reports  | report_valid, report_stall, report_item  | taken on valid && !stall
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data| written on valid && ready
//
// A sample that does not close a window is taken in S_IDLE. The sample that closes
// a window holds off input through five steps (average, microvolts, divider ratio,
// millivolts, low flag) and the 23-step percent divide, which is skipped when the
// percent is 0 or 100. A changed reading then waits in S_REPORT while a stalled
// report holds the output register. Reset (rst, synchronous) restores the register
// defaults and empties the window; the first completed window always reports.
module battery_level_monitor import blm_pkg::*; #(
  parameter int SAMPLES_PER_READING = SAMPLES_PER_READING_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  sample_item_t          sample_item,
  output logic                  report_valid,
  input  logic                  report_stall,
  output report_item_t          report_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  blm_cmd_t    cmd;
  blm_status_t status;

  assign cfg_ready = 1'b1;

  blm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .status       (status),
    .cmd          (cmd)
  );

  blm_datapath #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_item (sample_item),
    .cmd         (cmd),
    .status      (status),
    .report_item (report_item)
  );

  // No new divide while one is running
  assert property (@(posedge clk) disable iff (rst) cmd.div_start |-> !status.div_busy)
    else $error("divider restarted while busy");

  // Samples are only taken while the divider is idle
  assert property (@(posedge clk) disable iff (rst) cmd.acc_en |-> !status.div_busy)
    else $error("sample accumulated during window computation");

  // A held report is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!report_valid || !report_stall))
    else $error("result register loaded while a report is stalled");

  // Divider completion follows a busy cycle
  assert property (@(posedge clk) disable iff (rst) status.div_done |-> $past(status.div_busy))
    else $error("divider done without a running divide");

endmodule

// ----- tb/sv/blm_report_checker.sv -----
// Checker that predicts battery level reports from observed samples and compares them.
module blm_report_checker import blm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  input  logic                  sample_stall,
  input  sample_item_t          sample_item,
  input  logic                  report_valid,
  input  logic                  report_stall,
  input  report_item_t          report_item,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    reports_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the configuration registers
  logic [UVPC_W-1:0]  uv_per_count;
  logic [RATIO_W-1:0] ratio_q8;
  logic [MV_W-1:0]    empty_mv;
  logic [MV_W-1:0]    full_mv;

  // Shadow copy of the window and last-report state
  logic [15:0]        window_sum;
  int                 window_fill;
  logic               have_report;
  logic [15:0]        last_mv;
  logic [PCT_W-1:0]   last_pct;
  logic               last_low;

  report_item_t       expected_reports[$];
  int                 errors = 0;

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  // Average the window, scale to millivolts and queue a report if it moved
  task automatic close_window();
    longint           avg;
    longint           uv;
    longint           mv;
    longint           lo;
    longint           hi;
    longint           span;
    longint           gap;
    logic [PCT_W-1:0] pct;
    logic             low;
    report_item_t     rpt;
    avg = longint'(window_sum) / SAMPLES_PER_READING_DEF;
    window_sum = '0;
    window_fill = 0;
    uv = avg * longint'(uv_per_count);
    if (ratio_q8 > RATIO_ONE) begin
      uv = (uv * longint'(ratio_q8)) >>> RATIO_FRAC;
    end
    mv = (uv + 500) / 1000;
    if (mv < longint'(MV_MIN)) mv = longint'(MV_MIN);
    if (mv > longint'(MV_MAX)) mv = longint'(MV_MAX);
    lo = longint'(empty_mv);
    hi = longint'(full_mv);
    if (mv <= lo) begin
      pct = PCT_NONE;
    end else if (mv >= hi) begin
      pct = PCT_FULL;
    end else begin
      span = hi - lo;
      pct = PCT_W'(((mv - lo) * 200 + span) / (2 * span));
    end
    // Low threshold in tenths of a millivolt; span may be negative
    low = (10 * mv <= 10 * lo + (hi - lo));
    gap = mv - longint'(last_mv);
    if (gap < 0) gap = -gap;
    if (!have_report || pct != last_pct || gap > longint'(MV_HYST) || low != last_low) begin
      have_report = 1'b1;
      last_mv = 16'(mv);
      last_pct = pct;
      last_low = low;
      rpt.level_millivolts = MV_W'(mv);
      rpt.charge_percent = pct;
      rpt.is_low = low;
      expected_reports.push_back(rpt);
    end
  endtask

  // Compare an accepted report with the oldest expectation
  task automatic check_report();
    report_item_t want;
    if (expected_reports.size() == 0) begin
      flag_mismatch($sformatf("unexpected report %0d mV %0d %% low %0b",
                              report_item.level_millivolts, report_item.charge_percent,
                              report_item.is_low));
    end else begin
      want = expected_reports.pop_front();
      if (report_item.level_millivolts !== want.level_millivolts)
        flag_mismatch($sformatf("level_millivolts got %0d want %0d",
                                report_item.level_millivolts, want.level_millivolts));
      if (report_item.charge_percent !== want.charge_percent)
        flag_mismatch($sformatf("charge_percent got %0d want %0d",
                                report_item.charge_percent, want.charge_percent));
      if (report_item.is_low !== want.is_low)
        flag_mismatch($sformatf("is_low got %0b want %0b",
                                report_item.is_low, want.is_low));
    end
  endtask

  // Track every handshake at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      uv_per_count = UVPC_RST;
      ratio_q8 = RATIO_RST;
      empty_mv = EMPTY_RST;
      full_mv = FULL_RST;
      window_sum = '0;
      window_fill = 0;
      have_report = 1'b0;
      last_mv = '0;
      last_pct = '0;
      last_low = 1'b0;
      expected_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_e'(cfg_index))
          CFG_UV_PER_COUNT: uv_per_count = cfg_data[UVPC_W-1:0];
          CFG_RATIO_Q8:     ratio_q8 = cfg_data[RATIO_W-1:0];
          CFG_EMPTY_MV:     empty_mv = cfg_data[MV_W-1:0];
          CFG_FULL_MV:      full_mv = cfg_data[MV_W-1:0];
          default: ;
        endcase
      end
      if (report_valid && !report_stall) begin
        check_report();
      end
      if (sample_valid && !sample_stall) begin
        if (!sample_item.read_failed) begin
          window_sum = window_sum + 16'(sample_item.sample & SAMPLE_MASK);
        end
        window_fill++;
        if (window_fill >= SAMPLES_PER_READING_DEF) close_window();
      end
    end
    mismatch_count <= errors;
    reports_pending <= expected_reports.size();
  end

endmodule

// ----- tb/sv/tb_battery_level_monitor.sv -----
// Top of the battery level monitor testbench: clock, reset, stimulus and verdict.
module tb_battery_level_monitor import blm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW      = SAMPLES_PER_READING_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 150;
  localparam int HOLD_CYCLES = 1500;
  localparam int PHASES      = 12;
  localparam int BURST       = 160;

  logic                  clk;
  logic                  rst;
  logic                  sample_valid;
  logic                  sample_stall;
  sample_item_t          sample_item;
  logic                  report_valid;
  logic                  report_stall;
  report_item_t          report_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int pending;
  int send_idle = 28;
  int recv_idle = 87;
  int holds_requested = 0;
  int holds_served = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int samples_sent = 0;
  int level = 0;
  int fail_pct = 5;
  logic noisy = 1'b0;

  battery_level_monitor u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_item  (sample_item),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .report_item  (report_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  blm_report_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .sample_valid    (sample_valid),
    .sample_stall    (sample_stall),
    .sample_item     (sample_item),
    .report_valid    (report_valid),
    .report_stall    (report_stall),
    .report_item     (report_item),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatches),
    .reports_pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a run that hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("battery_level_monitor test failed");
    $finish;
  end

  // Drive report_stall: random stalls, or a long hold-off on request
  initial begin
    report_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_requested) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        report_stall <= 1'b1;
      end else begin
        report_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  // Offer one sample item and hold it until it is taken
  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic failed);
    while ($urandom_range(99) < send_idle) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_item <= '{sample: value, read_failed: failed};
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    samples_sent++;
  endtask

  // Send samples; pick a level and failure rate at each window start
  task automatic send_burst(input int count);
    int k;
    int s;
    int style;
    for (k = 0; k < count; k++) begin
      if (samples_sent % WINDOW == 0) begin
        style = $urandom_range(9);
        noisy = 1'b0;
        fail_pct = ($urandom_range(7) == 0) ? 50 : 5;
        if (style <= 3) begin
          // stay close to the last level to exercise the hysteresis
          level = level + int'($urandom_range(40)) - 20;
        end else if (style <= 7) begin
          level = int'($urandom_range(4095));
        end else if (style == 8) begin
          level = $urandom_range(1) ? 4095 : 0;
        end else begin
          noisy = 1'b1;
        end
        if (level < 0) level = 0;
        if (level > 4095) level = 4095;
      end
      if (noisy) begin
        s = int'($urandom_range(4095));
      end else begin
        s = level + int'($urandom_range(8)) - 4;
        if (s < 0) s = 0;
        if (s > 4095) s = 4095;
      end
      send_sample(SAMPLE_W'(s), ($urandom_range(99) < fail_pct));
    end
  endtask

  // Stop sending, let the last window finish, then wait for every expected report
  task automatic drain();
    sample_valid <= 1'b0;
    repeat (SETTLE) @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input int uvpc, input int ratio, input int empty_v, input int full_v);
    drain();
    write_reg(CFG_UV_PER_COUNT, uvpc);
    write_reg(CFG_RATIO_Q8, ratio);
    write_reg(CFG_EMPTY_MV, empty_v);
    write_reg(CFG_FULL_MV, full_v);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus: directed windows, then phases of settings with random samples
  initial begin
    int phase;
    int k;
    int uvpc_v;
    int ratio_v;
    int empty_v;
    int full_v;
    rst <= 1'b1;
    sample_valid <= 1'b0;
    sample_item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_UV_PER_COUNT;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == 4) begin
        send_idle = 87;
        recv_idle = 28;
      end
      if (phase == 8) begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (phase)
        0: ;
        1: configure(4095, 8191, 0, 20000);
        2: configure(1, 0, 20000, 0);
        3: configure(1000, 257, 3000, 3000);
        4: configure(800, 256, 0, 0);
        7: configure(4095, 256, 20000, 20000);
        default: begin
          uvpc_v = $urandom_range(1) ? int'($urandom_range(4095, 1)) : int'($urandom_range(1200, 600));
          case ($urandom_range(2))
            0: ratio_v = $urandom_range(256);
            1: ratio_v = $urandom_range(8191, 257);
            default: ratio_v = $urandom_range(1300, 256);
          endcase
          empty_v = $urandom_range(12000);
          if ($urandom_range(3) != 0) begin
            full_v = empty_v + int'($urandom_range(6000));
            if (full_v > 20000) full_v = 20000;
          end else begin
            full_v = $urandom_range(20000);
          end
          configure(uvpc_v, ratio_v, empty_v, full_v);
        end
      endcase

      if (phase == 0) begin
        // full scale window, an all-failed window, then a mixed one
        for (k = 0; k < WINDOW; k++) send_sample('1, 1'b0);
        for (k = 0; k < WINDOW; k++) send_sample('1, 1'b1);
        for (k = 0; k < WINDOW; k++) send_sample(k[0] ? '1 : '0, (k == 5));
      end

      if (phase == 6) begin
        send_burst(BURST / 2);
        drain();
        send_burst(BURST / 2);
      end else if (phase == 9) begin
        holds_requested++;
        send_burst(BURST);
      end else begin
        send_burst(BURST);
      end
    end

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("battery_level_monitor test passed");
    end else begin
      $display("battery_level_monitor test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/blm_pkg.sv
hdl/blm_div.sv
hdl/blm_datapath.sv
hdl/blm_ctrl.sv
hdl/battery_level_monitor.sv
tb/sv/blm_report_checker.sv
tb/sv/tb_battery_level_monitor.sv
